@@ design/power_retry_fault_manager_macros.svh @@
// assertion macros for the power retry fault manager
// used by design files that carry concurrent checks; no other dependencies
`ifndef POWER_RETRY_FAULT_MANAGER_MACROS_SVH
`define POWER_RETRY_FAULT_MANAGER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is low
`define PRFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prfm check failed");

// next-cycle implication, disabled while reset is low
`define PRFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prfm check failed");

`else

`define PRFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PRFM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/prfm_pkg.sv @@
// types and codes for the power retry fault manager
// no dependencies; imported by power_retry_fault_manager
`timescale 1ns / 1ps
`default_nettype none

package prfm_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 2;

    // supervisor states
    localparam logic [1:0] MODE_RESET   = 2'd0;
    localparam logic [1:0] MODE_FAULT   = 2'd1;
    localparam logic [1:0] MODE_POWERED = 2'd2;

    // requests
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // events
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_POWERED   = 2'd1;
    localparam logic [1:0] EV_RETRY     = 2'd2;
    localparam logic [1:0] EV_GATE_STOP = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILIZE   = 2'd2;

    // configuration reset values
    localparam logic [COUNT_W-1:0] FAULT_LIMIT_RST = 8'd0;
    localparam logic [TIME_W-1:0]  RETRY_DELAY_RST = 32'd1000;
    localparam logic [TIME_W-1:0]  STABILIZE_RST   = 32'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TIME_W-1:0] now_time;
        logic              gate_active;
    } t_in_item;

    typedef struct packed {
        logic       power_enable;
        logic [1:0] current_state;
        logic [1:0] event_code;
        logic       event_valid;
    } t_out_item;

endpackage

`default_nettype wire

@@ design/power_retry_fault_manager.sv @@
// power retry fault manager: three-state supervisor for a high-voltage enable
// depends on prfm_pkg and power_retry_fault_manager_macros.svh
//
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out       out  o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while no result is held: a beat is captured in the input
// register, evaluated against the state registers and stored in the result
// register. the state update loop (mode, entry time, fault count) loads with
// the result register; a held result stalls both and the input register.
// reset is synchronous, active low; config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
`include "power_retry_fault_manager_macros.svh"

module power_retry_fault_manager
    import prfm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data
);

    logic               r_in_vld;
    t_in_item           r_in;
    logic               r_out_vld;
    t_out_item          r_out;

    logic [1:0]         r_mode;
    logic [TIME_W-1:0]  r_entry_time;
    logic [COUNT_W-1:0] r_fault_count;

    logic [COUNT_W-1:0] r_fault_limit;
    logic [TIME_W-1:0]  r_retry_delay;
    logic [TIME_W-1:0]  r_stabilize;

    logic [1:0]         n_mode;
    logic [TIME_W-1:0]  n_entry_time;
    logic [COUNT_W-1:0] n_fault_count;
    logic [1:0]         w_event;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_retry_ok;
    logic               w_adv;

    // evaluate the held beat when the result register is free or draining
    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_elapsed  = r_in.now_time - r_entry_time;
    assign w_retry_ok = (r_fault_limit == '0) || (r_fault_count < r_fault_limit);

    always_comb begin
        n_mode        = r_mode;
        n_entry_time  = r_entry_time;
        n_fault_count = r_fault_count;
        w_event       = EV_NONE;
        if (r_in.operation == OP_RUN && r_mode != MODE_POWERED) begin
            n_mode       = MODE_POWERED;
            n_entry_time = r_in.now_time;
            w_event      = EV_POWERED;
        end else if (r_in.operation == OP_RESET && r_mode != MODE_RESET) begin
            n_mode        = MODE_RESET;
            n_entry_time  = r_in.now_time;
            n_fault_count = '0;
        end else begin
            case (r_mode)
                MODE_RESET: begin
                end
                MODE_FAULT: begin
                    if (w_elapsed > r_retry_delay && w_retry_ok) begin
                        n_mode       = MODE_POWERED;
                        n_entry_time = r_in.now_time;
                        w_event      = EV_RETRY;
                    end
                end
                MODE_POWERED: begin
                    if (w_elapsed > r_stabilize && !r_in.gate_active) begin
                        n_mode       = MODE_FAULT;
                        n_entry_time = r_in.now_time;
                        w_event      = EV_GATE_STOP;
                        if (r_fault_count != COUNT_MAX) begin
                            n_fault_count = r_fault_count + COUNT_W'(1);
                        end
                    end
                end
                default: begin
                    // unused mode code falls back to reset
                    n_mode        = MODE_RESET;
                    n_entry_time  = r_in.now_time;
                    n_fault_count = '0;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.power_enable  <= (n_mode == MODE_POWERED);
            r_out.current_state <= n_mode;
            r_out.event_code    <= w_event;
            r_out.event_valid   <= (w_event != EV_NONE);
        end
    end

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RESET;
            r_entry_time  <= '0;
            r_fault_count <= '0;
        end else if (w_adv) begin
            r_mode        <= n_mode;
            r_entry_time  <= n_entry_time;
            r_fault_count <= n_fault_count;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_limit <= FAULT_LIMIT_RST;
            r_retry_delay <= RETRY_DELAY_RST;
            r_stabilize   <= STABILIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FAULT_LIMIT: r_fault_limit <= i_cfg_data[COUNT_W-1:0];
                CFG_RETRY_DELAY: r_retry_delay <= i_cfg_data;
                CFG_STABILIZE:   r_stabilize   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    `PRFM_ASSERT_NXT(a_gate_stop_counts, i_clk, i_rst_n, w_adv && w_event == EV_GATE_STOP, r_fault_count != '0)
    `PRFM_ASSERT_NXT(a_reset_clears, i_clk, i_rst_n, w_adv && n_mode == MODE_RESET, r_fault_count == '0)
    `PRFM_ASSERT_NXT(a_state_holds, i_clk, i_rst_n, !w_adv, $stable(r_mode) && $stable(r_entry_time) && $stable(r_fault_count))
    `PRFM_ASSERT_IMP(a_enable_match, i_clk, i_rst_n, r_out_vld, r_out.power_enable == (r_out.current_state == MODE_POWERED))
    `PRFM_ASSERT_NXT(a_retry_event, i_clk, i_rst_n, w_adv && w_event == EV_RETRY, r_mode == MODE_POWERED && r_out.event_valid)

endmodule

`default_nettype wire

@@ tb/tb_power_retry_fault_manager.sv @@
// self-checking testbench for power_retry_fault_manager: directed table, random phases,
// then a saturation run; depends on prfm_pkg and the power_retry_fault_manager top level
`timescale 1ns / 1ps

module tb_power_retry_fault_manager;
    import prfm_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0]           OP_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam t_out_item OUT_RESET_IDLE = {1'b0, MODE_RESET, EV_NONE, 1'b0};
    localparam t_out_item OUT_POWER_UP   = {1'b1, MODE_POWERED, EV_POWERED, 1'b1};
    localparam t_out_item OUT_GATE_STOP  = {1'b0, MODE_FAULT, EV_GATE_STOP, 1'b1};
    localparam t_out_item OUT_RETRY      = {1'b1, MODE_POWERED, EV_RETRY, 1'b1};
    localparam logic [6:0] PRED_ONLY     = '0;

    typedef struct packed {
        t_in_item  req;
        logic      typed_ok;
        t_out_item typed;
    } t_dir_row;

    // runs with the reset configuration: stabilize 100, retry 1000, no fault limit
    localparam int DIR_ROWS = 19;
    localparam t_dir_row DIRECTED_PLAN [DIR_ROWS] = '{
        {OP_NONE,  32'd0,          1'b0, 1'b1, OUT_RESET_IDLE},
        {OP_RESET, 32'd5,          1'b0, 1'b1, OUT_RESET_IDLE},
        {OP_SPARE, 32'd10,         1'b1, 1'b1, OUT_RESET_IDLE},
        {OP_RUN,   32'd20,         1'b1, 1'b1, OUT_POWER_UP},
        {OP_RUN,   32'd30,         1'b0, PRED_ONLY},
        {OP_NONE,  32'd120,        1'b0, PRED_ONLY},
        {OP_NONE,  32'd121,        1'b1, PRED_ONLY},
        {OP_NONE,  32'd121,        1'b0, 1'b1, OUT_GATE_STOP},
        {OP_NONE,  32'd1121,       1'b0, PRED_ONLY},
        {OP_NONE,  32'd1122,       1'b1, 1'b1, OUT_RETRY},
        {OP_NONE,  32'd1300,       1'b0, 1'b1, OUT_GATE_STOP},
        {OP_RUN,   32'd1301,       1'b0, 1'b1, OUT_POWER_UP},
        {OP_RESET, 32'd1302,       1'b1, 1'b1, OUT_RESET_IDLE},
        {OP_RUN,   32'hFFFF_FFF0,  1'b1, 1'b1, OUT_POWER_UP},
        {OP_NONE,  32'h0000_0050,  1'b0, PRED_ONLY},
        {OP_NONE,  32'h0000_0055,  1'b0, 1'b1, OUT_GATE_STOP},
        {OP_SPARE, 32'hFFFF_FFFF,  1'b1, 1'b1, OUT_RETRY},
        {OP_RESET, 32'd0,          1'b0, 1'b1, OUT_RESET_IDLE},
        {OP_NONE,  32'hFFFF_FFFF,  1'b1, 1'b1, OUT_RESET_IDLE}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TIME_W-1:0]    i_cfg_data;

    power_retry_fault_manager u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // supervisor copy and its registers
    logic [1:0]         sup_mode   = MODE_RESET;
    logic [TIME_W-1:0]  sup_entry  = '0;
    logic [COUNT_W-1:0] sup_faults = '0;
    logic [COUNT_W-1:0] lim_reg    = FAULT_LIMIT_RST;
    logic [TIME_W-1:0]  retry_reg  = RETRY_DELAY_RST;
    logic [TIME_W-1:0]  stab_reg   = STABILIZE_RST;

    t_out_item         pending_outputs[$];
    logic [TIME_W-1:0] last_now      = '0;
    int                mismatches    = 0;
    int                long_hold_cnt = 0;
    bit                in_gaps_on    = 1'b1;
    bit                out_stalls_on = 1'b1;

    function automatic void enter_mode(input logic [1:0] next, input logic [TIME_W-1:0] now);
        sup_mode  = next;
        sup_entry = now;
        if (next == MODE_RESET) begin
            sup_faults = '0;
        end else if (next == MODE_FAULT && sup_faults != COUNT_MAX) begin
            sup_faults = sup_faults + 1'b1;
        end
    endfunction

    function automatic t_out_item step_supervisor(input t_in_item req);
        t_out_item         res;
        logic [1:0]        ev;
        logic [TIME_W-1:0] elapsed;
        ev      = EV_NONE;
        elapsed = req.now_time - sup_entry;
        if (req.operation == OP_RUN && sup_mode != MODE_POWERED) begin
            enter_mode(MODE_POWERED, req.now_time);
            ev = EV_POWERED;
        end else if (req.operation == OP_RESET && sup_mode != MODE_RESET) begin
            enter_mode(MODE_RESET, req.now_time);
        end else if (sup_mode == MODE_FAULT) begin
            if (elapsed > retry_reg && (lim_reg == '0 || sup_faults < lim_reg)) begin
                enter_mode(MODE_POWERED, req.now_time);
                ev = EV_RETRY;
            end
        end else if (sup_mode == MODE_POWERED) begin
            if (elapsed > stab_reg && !req.gate_active) begin
                enter_mode(MODE_FAULT, req.now_time);
                ev = EV_GATE_STOP;
            end
        end
        res.power_enable  = (sup_mode == MODE_POWERED);
        res.current_state = sup_mode;
        res.event_code    = ev;
        res.event_valid   = (ev != EV_NONE);
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // timestamps cluster around the timeout that matters in the predicted state
    function automatic t_in_item random_request();
        t_in_item          req;
        logic [TIME_W-1:0] span;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 70)
            req.operation = OP_NONE;
        else if (r < 84)
            req.operation = OP_RUN;
        else if (r < 94)
            req.operation = OP_RESET;
        else
            req.operation = OP_SPARE;
        span = (sup_mode == MODE_FAULT) ? retry_reg : stab_reg;
        r = $urandom_range(0, 9);
        if (r < 4)
            req.now_time = last_now + $urandom_range(0, 20);
        else if (r < 7)
            req.now_time = sup_entry + span + $urandom_range(0, 3) - 1;
        else if (r < 9)
            req.now_time = last_now + $urandom_range(0, 2000);
        else
            req.now_time = $urandom;
        req.gate_active = ($urandom_range(0, 9) < 6);
        return req;
    endfunction

    // called at a rising edge; returns at the edge that accepts the beat
    task automatic offer_item(input t_in_item req, input logic typed_ok = 1'b0,
                              input t_out_item typed = '0);
        t_out_item pred;
        int        gap;
        gap = pick_gap(in_gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pred     = step_supervisor(req);
        last_now = req.now_time;
        pending_outputs.push_back(typed_ok ? typed : pred);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FAULT_LIMIT: lim_reg   = val[COUNT_W-1:0];
            CFG_RETRY_DELAY: retry_reg = val;
            CFG_STABILIZE:   stab_reg  = val;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stim
        int                k;
        int                phase;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] lim_data;
        logic [TIME_W-1:0] retry_data;
        logic [TIME_W-1:0] stab_data;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            offer_item(DIRECTED_PLAN[k].req, DIRECTED_PLAN[k].typed_ok, DIRECTED_PLAN[k].typed);

        for (phase = 0; phase < 11; phase++) begin
            drain();
            case (phase)
                0: begin
                    lim_data = 32'd0;  retry_data = 32'd0;  stab_data = 32'hFFFF_FFFF;
                end
                1: begin
                    lim_data = 32'd1;  retry_data = 32'hFFFF_FFFF;  stab_data = 32'd0;
                end
                2: begin
                    lim_data = 32'd255;  retry_data = 32'd1;  stab_data = 32'd0;
                end
                3: begin
                    lim_data = ($urandom & 32'hFFFF_FF00) | 32'd2;
                    retry_data = 32'd50;  stab_data = 32'd20;
                end
                4: begin
                    lim_data = 32'd0;  retry_data = $urandom;  stab_data = $urandom;
                end
                default: begin
                    lim_data   = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 4);
                    retry_data = $urandom_range(0, 400);
                    stab_data  = $urandom_range(0, 300);
                end
            endcase
            // the spare index must leave every register alone
            if (phase == 0)
                cfg_beat(CFG_UNUSED, $urandom);
            cfg_beat(CFG_FAULT_LIMIT, lim_data);
            cfg_beat(CFG_RETRY_DELAY, retry_data);
            cfg_beat(CFG_STABILIZE, stab_data);
            cfg_done();
            in_gaps_on    = (phase % 3 != 1);
            out_stalls_on = (phase % 4 != 2);
            if (phase == 3) begin
                // keep offering while the output is held so the input backs up
                in_gaps_on    = 1'b0;
                long_hold_cnt = 300;
            end
            repeat (110) offer_item(random_request());
        end

        // fault count saturation: gate loss and retry alternate with no reset until the count reaches the limit
        drain();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        cfg_beat(CFG_FAULT_LIMIT, 32'd255);
        cfg_beat(CFG_RETRY_DELAY, 32'd0);
        cfg_beat(CFG_STABILIZE, 32'd0);
        cfg_done();
        t = last_now;
        offer_item({OP_RESET, t, 1'b1});
        t = t + 1;
        offer_item({OP_RUN, t, 1'b1});
        for (k = 0; k < 270; k++) begin
            t = t + 1;
            offer_item({OP_NONE, t, 1'b0});
            t = t + 1;
            offer_item({OP_NONE, t, 1'b1});
        end
        // count pinned at the limit: forced run, fault again, no retry
        t = t + 1;
        offer_item({OP_RUN, t, 1'b0});
        t = t + 1;
        offer_item({OP_NONE, t, 1'b0});
        t = t + 1;
        offer_item({OP_NONE, t, 1'b1});
        drain();
        cfg_beat(CFG_FAULT_LIMIT, 32'd0);
        cfg_done();
        t = t + 1;
        offer_item({OP_NONE, t, 1'b1});

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : out_stall_gen
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cnt > 0) begin
                i_out_ready <= 1'b0;
                long_hold_cnt = long_hold_cnt - 1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left = stall_left - 1;
            end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = pick_gap(1'b1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("result beat with nothing expected: %h", o_out_data);
                mismatches = mismatches + 1;
            end else begin
                exp = pending_outputs.pop_front();
                if (o_out_data.power_enable !== exp.power_enable) begin
                    $error("power_enable: expected %0d, actual %0d",
                           exp.power_enable, o_out_data.power_enable);
                    mismatches = mismatches + 1;
                end
                if (o_out_data.current_state !== exp.current_state) begin
                    $error("current_state: expected %0d, actual %0d",
                           exp.current_state, o_out_data.current_state);
                    mismatches = mismatches + 1;
                end
                if (o_out_data.event_code !== exp.event_code) begin
                    $error("event_code: expected %0d, actual %0d",
                           exp.event_code, o_out_data.event_code);
                    mismatches = mismatches + 1;
                end
                if (o_out_data.event_valid !== exp.event_valid) begin
                    $error("event_valid: expected %0d, actual %0d",
                           exp.event_valid, o_out_data.event_valid);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
